>>> rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/cmts_pkg.sv
// types and constants of the clock mode and time set controller
`default_nettype none

package cmts_pkg;

  typedef enum logic [2:0] {
    MD_IDLE   = 3'd0,
    MD_NIGHT  = 3'd1,
    MD_ACTIVE = 3'd2,
    MD_SETH   = 3'd3,
    MD_SETM   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_LEFT_CLICK  = 3'd1,
    ACT_RIGHT_CLICK = 3'd2,
    ACT_LEFT_LONG   = 3'd3,
    ACT_RIGHT_LONG  = 3'd4
  } action_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_NIGHT_START = 3'd0,
    CFG_DAY_START   = 3'd1,
    CFG_IDLE_TMO    = 3'd2,
    CFG_FRAME_PER   = 3'd3,
    CFG_BLINK_PER   = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [10:0] NIGHT_START_RST = 11'd1200;
  localparam logic [10:0] DAY_START_RST   = 11'd480;
  localparam logic [15:0] IDLE_TMO_RST    = 16'd10000;
  localparam logic [9:0]  FRAME_PER_RST   = 10'd30;
  localparam logic [11:0] BLINK_PER_RST   = 12'd300;

  localparam logic [4:0]  HOUR_MAX      = 5'd23;
  localparam logic [5:0]  MINUTE_MAX    = 6'd59;
  localparam logic [10:0] MIN_PER_HOUR  = 11'd60;
  localparam logic [2:0]  BRIGHT_NORMAL = 3'd3;
  localparam logic [2:0]  BRIGHT_NIGHT  = 3'd1;

  typedef struct packed {
    logic [10:0] night_start_minute;
    logic [10:0] day_start_minute;
    logic [15:0] idle_timeout_ms;
    logic [9:0]  frame_period_ms;
    logic [11:0] blink_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now_ms;
    logic [4:0]  rtc_hour;
    logic [5:0]  rtc_minute;
    logic [5:0]  rtc_second;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic       frame_done;
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
    logic       colon_on;
    logic       blank_hours;
    logic       blank_minutes;
    logic [2:0] brightness_level;
    logic       rtc_write;
    logic [4:0] rtc_write_hour;
    logic [5:0] rtc_write_minute;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/cmts_in_if.sv
// input channel: one main-loop pass per transfer
`default_nettype none

interface cmts_in_if;
  logic               valid;
  logic               ready;
  cmts_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/cmts_out_if.sv
// result channel: one display and rtc result per transfer
`default_nettype none

interface cmts_out_if;
  logic                valid;
  logic                ready;
  cmts_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/clock_mode_and_time_set_fsm_unit.sv
// top level: config registers, input register and result register around the step logic
//
// Digital clock mode and time set controller. Each input transfer on in_i is one
// main-loop pass: a button action, the millisecond time and the rtc time. Each
// pass yields exactly one result transfer on out_o with the mode, the display
// frame contents and an optional rtc write strobe.
// Configuration: write cfg_we_i with a register index on cfg_idx_i and the value
// on cfg_wdata_i; write only while no transfer is in flight.
// Path: each pass goes through the input register, then the step logic, then the
// result register, from which out_o presents it.
// Throughput: one pass per cycle while out_o is not held; the mode and timer update
// is combinational compare and select logic between the input and result registers.
// Stall: while out_o is held, the input register keeps one more pass and then
// in_i.ready drops until the result is taken.
// Reset: asynchronous, active low; mode idle, timers zero, digits visible,
// brightness normal, configuration at its default values.
`default_nettype none
`include "assert_macros.svh"

module clock_mode_and_time_set_fsm_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cmts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cmts_pkg::CfgDataW-1:0]  cfg_wdata_i,
  cmts_in_if.sink                             in_i,
  cmts_out_if.source                          out_o
);

  cmts_pkg::cfg_t      cfg_q;
  logic                s1_valid_q, s1_valid_d;
  cmts_pkg::in_item_t  s1_item_q;
  logic                out_valid_q, out_valid_d;
  cmts_pkg::out_item_t out_item_q;
  cmts_pkg::out_item_t res;
  logic                in_xfer;
  logic                adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.night_start_minute <= cmts_pkg::NIGHT_START_RST;
      cfg_q.day_start_minute   <= cmts_pkg::DAY_START_RST;
      cfg_q.idle_timeout_ms    <= cmts_pkg::IDLE_TMO_RST;
      cfg_q.frame_period_ms    <= cmts_pkg::FRAME_PER_RST;
      cfg_q.blink_period_ms    <= cmts_pkg::BLINK_PER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cmts_pkg::CFG_NIGHT_START: cfg_q.night_start_minute <= cfg_wdata_i[10:0];
        cmts_pkg::CFG_DAY_START:   cfg_q.day_start_minute   <= cfg_wdata_i[10:0];
        cmts_pkg::CFG_IDLE_TMO:    cfg_q.idle_timeout_ms    <= cfg_wdata_i;
        cmts_pkg::CFG_FRAME_PER:   cfg_q.frame_period_ms    <= cfg_wdata_i[9:0];
        cmts_pkg::CFG_BLINK_PER:   cfg_q.blink_period_ms    <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // the pass runs when the result register is free or being drained
  assign adv        = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_xfer || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_i.data;
    end
    if (adv) begin
      out_item_q <= res;
    end
  end

  cmts_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  `ASSERT_NEXT(s1_holds_a, clk_i, rst_ni, s1_valid_q && !adv,
               s1_valid_q && s1_item_q == $past(s1_item_q))
  `ASSERT_IMPL(ready_low_only_on_stall_a, clk_i, rst_ni, !in_i.ready,
               s1_valid_q && out_valid_q && !out_o.ready)
  `ASSERT_IMPL(blank_exclusive_a, clk_i, rst_ni, out_valid_q,
               !(out_item_q.blank_hours && out_item_q.blank_minutes))

endmodule

`default_nettype wire

>>> rtl/cmts_step.sv
// mode state machine, edit registers and timers: one pass per enabled cycle
`default_nettype none
`include "assert_macros.svh"

module cmts_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire cmts_pkg::in_item_t  item_i,
  input  wire cmts_pkg::cfg_t      cfg_i,
  output cmts_pkg::out_item_t      res_o
);

  cmts_pkg::mode_e mode_q, mode_d;
  logic [4:0]  edit_hour_q, edit_hour_d;
  logic [5:0]  edit_minute_q, edit_minute_d;
  logic [31:0] last_act_q, last_act_d;
  logic [31:0] last_frame_q, last_frame_d;
  logic [31:0] last_blink_q, last_blink_d;
  logic        blink_vis_q, blink_vis_d;
  logic [2:0]  bright_q, bright_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cmts_pkg::MD_IDLE;
    end else if (en_i) begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_hour_q   <= '0;
      edit_minute_q <= '0;
      last_act_q    <= '0;
      last_frame_q  <= '0;
      last_blink_q  <= '0;
      blink_vis_q   <= 1'b1;
      bright_q      <= cmts_pkg::BRIGHT_NORMAL;
    end else if (en_i) begin
      edit_hour_q   <= edit_hour_d;
      edit_minute_q <= edit_minute_d;
      last_act_q    <= last_act_d;
      last_frame_q  <= last_frame_d;
      last_blink_q  <= last_blink_d;
      blink_vis_q   <= blink_vis_d;
      bright_q      <= bright_d;
    end
  end

  always_comb begin
    logic [31:0] now;
    logic [31:0] since_frame;
    logic [31:0] since_act;
    logic [31:0] since_blink;
    logic [10:0] minute_of_day;

    now = item_i.now_ms;
    mode_d        = mode_q;
    edit_hour_d   = edit_hour_q;
    edit_minute_d = edit_minute_q;
    last_act_d    = last_act_q;
    last_frame_d  = last_frame_q;
    last_blink_d  = last_blink_q;
    blink_vis_d   = blink_vis_q;
    bright_d      = bright_q;
    res_o         = '0;

    // button event
    unique case (item_i.action)
      cmts_pkg::ACT_LEFT_CLICK: begin
        last_act_d = now;
        unique case (mode_q)
          cmts_pkg::MD_SETH: edit_hour_d = (edit_hour_q == cmts_pkg::HOUR_MAX) ?
                                           5'd0 : edit_hour_q + 5'd1;
          cmts_pkg::MD_SETM: edit_minute_d = (edit_minute_q == cmts_pkg::MINUTE_MAX) ?
                                             6'd0 : edit_minute_q + 6'd1;
          cmts_pkg::MD_IDLE: mode_d = cmts_pkg::MD_ACTIVE;
          default: ;
        endcase
      end
      cmts_pkg::ACT_RIGHT_CLICK: begin
        last_act_d = now;
        unique case (mode_q)
          cmts_pkg::MD_SETH: edit_hour_d = (edit_hour_q == 5'd0) ?
                                           cmts_pkg::HOUR_MAX : edit_hour_q - 5'd1;
          cmts_pkg::MD_SETM: edit_minute_d = (edit_minute_q == 6'd0) ?
                                             cmts_pkg::MINUTE_MAX : edit_minute_q - 6'd1;
          cmts_pkg::MD_IDLE: mode_d = cmts_pkg::MD_ACTIVE;
          default: ;
        endcase
      end
      cmts_pkg::ACT_LEFT_LONG: begin
        last_act_d = now;
        unique case (mode_q)
          cmts_pkg::MD_IDLE, cmts_pkg::MD_NIGHT: begin
            edit_hour_d = (item_i.rtc_hour > cmts_pkg::HOUR_MAX) ?
                          cmts_pkg::HOUR_MAX : item_i.rtc_hour;
            edit_minute_d = (item_i.rtc_minute > cmts_pkg::MINUTE_MAX) ?
                            cmts_pkg::MINUTE_MAX : item_i.rtc_minute;
            mode_d = cmts_pkg::MD_SETH;
          end
          cmts_pkg::MD_SETH: mode_d = cmts_pkg::MD_SETM;
          cmts_pkg::MD_SETM: begin
            res_o.rtc_write        = 1'b1;
            res_o.rtc_write_hour   = edit_hour_q;
            res_o.rtc_write_minute = edit_minute_q;
            mode_d = cmts_pkg::MD_IDLE;
          end
          default: ;
        endcase
      end
      cmts_pkg::ACT_RIGHT_LONG: last_act_d = now;
      default: ;
    endcase

    since_frame   = now - last_frame_q;
    since_act     = now - last_act_d;
    since_blink   = now - last_blink_q;
    minute_of_day = ({6'd0, item_i.rtc_hour} * cmts_pkg::MIN_PER_HOUR) +
                    {5'd0, item_i.rtc_minute};

    if (since_frame >= {22'd0, cfg_i.frame_period_ms}) begin
      res_o.frame_done = 1'b1;
      if (since_act > {16'd0, cfg_i.idle_timeout_ms} &&
          (mode_d == cmts_pkg::MD_IDLE || mode_d == cmts_pkg::MD_ACTIVE)) begin
        mode_d = cmts_pkg::MD_IDLE;
      end
      if (mode_d == cmts_pkg::MD_SETH || mode_d == cmts_pkg::MD_SETM) begin
        if (since_blink >= {20'd0, cfg_i.blink_period_ms}) begin
          blink_vis_d  = !blink_vis_q;
          last_blink_d = now;
        end
        res_o.shown_hour    = edit_hour_d;
        res_o.shown_minute  = edit_minute_d;
        res_o.colon_on      = 1'b1;
        res_o.blank_hours   = !blink_vis_d && (mode_d == cmts_pkg::MD_SETH);
        res_o.blank_minutes = !blink_vis_d && (mode_d == cmts_pkg::MD_SETM);
      end else begin
        // brightness follows the mode before the night window check
        bright_d = (mode_d == cmts_pkg::MD_NIGHT) ?
                   cmts_pkg::BRIGHT_NIGHT : cmts_pkg::BRIGHT_NORMAL;
        res_o.shown_hour   = item_i.rtc_hour;
        res_o.shown_minute = item_i.rtc_minute;
        res_o.colon_on     = !item_i.rtc_second[0];
        if (minute_of_day >= cfg_i.night_start_minute ||
            minute_of_day < cfg_i.day_start_minute) begin
          mode_d = cmts_pkg::MD_NIGHT;
        end else if (mode_d == cmts_pkg::MD_NIGHT) begin
          mode_d = cmts_pkg::MD_IDLE;
        end
      end
      last_frame_d = now;
    end

    res_o.mode_now         = mode_d;
    res_o.brightness_level = bright_d;
  end

  `ASSERT_ALWAYS(edit_in_range_a, clk_i, rst_ni,
                 edit_hour_q <= cmts_pkg::HOUR_MAX && edit_minute_q <= cmts_pkg::MINUTE_MAX)
  `ASSERT_NEXT(frame_marks_time_a, clk_i, rst_ni, en_i && res_o.frame_done,
               last_frame_q == $past(item_i.now_ms))
  `ASSERT_NEXT(no_frame_keeps_time_a, clk_i, rst_ni, en_i && !res_o.frame_done,
               last_frame_q == $past(last_frame_q) && blink_vis_q == $past(blink_vis_q))

endmodule

`default_nettype wire
